// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL in this folder.
// Needs clk_i and rst_ni in the scope of each use; empty under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge out of reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Expression must never be true at a clock edge out of reset.
`define ASSERT_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`else

`define ASSERT_CLK(name, prop, msg)
`define ASSERT_NEVER(name, expr, msg)

`endif

`endif

// ===== rtl/core/nqse_pkg.sv =====
// Shared constants for the n-queens enumerator.
// No dependencies; imported by n_queens_solution_enumerator_top.
package nqse_pkg;

  localparam int MaxQueensDef = 8;
  localparam int BoardSizeW   = 4;
  localparam int RowW         = 4;
  localparam int PackW        = 32;
  localparam int PackCols     = 8;
  localparam int PackCntW     = $clog2(PackCols + 1);

  localparam logic [BoardSizeW-1:0] BoardSizeRst = BoardSizeW'(8);

endpackage

// ===== rtl/core/n_queens_solution_enumerator_top.sv =====
// N-queens enumerator: depth-first backtracking over a row stack held in a RAM.
// Depends on nqse_pkg and assert_macros.svh.
//
// Usage:
//   Request: pulse start_i with restart_i while busy_o is low. restart_i=1
//   begins a new search on an empty board; restart_i=0 resumes after the last
//   solution (a resume before any restart behaves as a restart).
//   Result: valid_o is high for exactly one cycle with found_o and
//   rows_packed_o (row of column k in bits 4k+3..4k). found_o=0 means the
//   search is exhausted; further resumes repeat that answer.
//   Configuration: cfg_we_i/cfg_wdata_i write board_size, only while idle.
// Timing:
//   The stack RAM has a registered read. Each row tried is a SEARCH step,
//   a column that runs out of rows adds a step into POP, each column popped is
//   a POP step (a resume first pops down to the resume column), and the
//   min(N,8) columns of the solution are read out in PACK; the result strobe is
//   registered after the last PACK step. So latency is search-dependent, one
//   request in flight at a time; an exhausted resume answers without a search.
//   Reset: board_size returns to 8 and the search state clears; the RAM is
//   not cleared, as every entry is written before it is read.
//   The receiver cannot stall; busy_o drops in the cycle the result shows.
`include "assert_macros.svh"

module n_queens_solution_enumerator_top
  import nqse_pkg::*;
#(
  parameter int MAX_QUEENS = MaxQueensDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  restart_i,
  input  logic                  cfg_we_i,
  input  logic [BoardSizeW-1:0] cfg_wdata_i,
  output logic                  valid_o,
  output logic                  found_o,
  output logic [PackW-1:0]      rows_packed_o
);

  localparam int CW  = $clog2(MAX_QUEENS + 1);
  localparam int AW  = (MAX_QUEENS > 1) ? $clog2(MAX_QUEENS) : 1;
  localparam int DN  = 2 * MAX_QUEENS - 1;
  localparam int DW  = (DN > 1) ? $clog2(DN) : 1;
  localparam int NW  = (CW > BoardSizeW) ? CW : BoardSizeW;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_POP    = 2'd2;
  localparam logic [1:0] ST_PACK   = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [BoardSizeW-1:0] board_size_q;
  logic [CW-1:0]         col_q, col_d;
  logic [CW-1:0]         r_q, r_d;
  logic [CW-1:0]         cur_q, cur_d;
  logic [CW-1:0]         tgt_q, tgt_d;
  logic                  done_q, done_d;
  logic                  started_q, started_d;
  logic [MAX_QUEENS-1:0] rows_q, rows_d;
  logic [DN-1:0]         d1_q, d1_d;
  logic [DN-1:0]         d2_q, d2_d;
  logic [PackCntW-1:0]   pk_q, pk_d;
  logic                  valid_q, valid_d;
  logic                  found_q, found_d;
  logic [PackW-1:0]      packed_q, packed_d;

  logic [RowW-1:0]       stack_mem [MAX_QUEENS];
  logic [RowW-1:0]       rdata_q;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [RowW-1:0]       mem_wdata;
  logic [AW-1:0]         mem_raddr;

  logic [NW-1:0]         bs_ext;
  logic [CW-1:0]         n;
  logic [PackCntW-1:0]   cnt;
  logic [CW-1:0]         depth;
  logic [CW-1:0]         col_m1, col_m2;
  logic [DW-1:0]         d1_idx, d2_idx, p1_idx, p2_idx;
  logic [AW-1:0]         r_idx, v_idx;
  logic                  free;
  logic [PackCntW-1:0]   pk_m1;

  assign bs_ext = NW'(board_size_q);
  assign n      = (bs_ext > NW'(MAX_QUEENS)) ? CW'(MAX_QUEENS) : CW'(bs_ext);
  assign cnt    = (NW'(n) > NW'(PackCols)) ? PackCntW'(PackCols) : PackCntW'(n);
  assign depth  = (cur_q > n) ? n : cur_q;
  assign col_m1 = col_q - CW'(1);
  assign col_m2 = col_q - CW'(2);
  assign pk_m1  = pk_q - PackCntW'(1);

  // candidate square against the masks of columns below col_q
  assign r_idx  = r_q[AW-1:0];
  assign d1_idx = DW'(r_q) + DW'(MAX_QUEENS - 1) - DW'(col_q);
  assign d2_idx = DW'(r_q) + DW'(col_q);
  assign free   = !rows_q[r_idx] && !d1_q[d1_idx] && !d2_q[d2_idx];

  // popped entry sits at column col_q-1
  assign v_idx  = rdata_q[AW-1:0];
  assign p1_idx = DW'(rdata_q) + DW'(MAX_QUEENS - 1) - DW'(col_m1);
  assign p2_idx = DW'(rdata_q) + DW'(col_m1);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= stack_mem[mem_raddr];
  end

  always_comb begin
    state_d   = state_q;
    col_d     = col_q;
    r_d       = r_q;
    cur_d     = cur_q;
    tgt_d     = tgt_q;
    done_d    = done_q;
    started_d = started_q;
    rows_d    = rows_q;
    d1_d      = d1_q;
    d2_d      = d2_q;
    pk_d      = pk_q;
    valid_d   = 1'b0;
    found_d   = found_q;
    packed_d  = packed_q;
    mem_we    = 1'b0;
    mem_waddr = col_q[AW-1:0];
    mem_wdata = RowW'(r_q);
    mem_raddr = col_m1[AW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (restart_i || !started_q) begin
            started_d = 1'b1;
            done_d    = 1'b0;
            cur_d     = '0;
            col_d     = '0;
            r_d       = '0;
            rows_d    = '0;
            d1_d      = '0;
            d2_d      = '0;
            pk_d      = '0;
            packed_d  = '0;
            state_d   = (n == '0) ? ST_PACK : ST_SEARCH;
          end else if (done_q || depth == '0) begin
            done_d   = 1'b1;
            cur_d    = '0;
            valid_d  = 1'b1;
            found_d  = 1'b0;
            packed_d = '0;
          end else begin
            // unwind the stack down to the resume column
            tgt_d   = depth - CW'(1);
            state_d = ST_POP;
          end
        end
      end

      ST_SEARCH: begin
        if (r_q < n) begin
          if (free) begin
            mem_we          = 1'b1;
            rows_d[r_idx]   = 1'b1;
            d1_d[d1_idx]    = 1'b1;
            d2_d[d2_idx]    = 1'b1;
            col_d           = col_q + CW'(1);
            r_d             = '0;
            if (col_q + CW'(1) >= n) begin
              cur_d    = n;
              done_d   = 1'b0;
              pk_d     = '0;
              packed_d = '0;
              state_d  = ST_PACK;
            end
          end else begin
            r_d = r_q + CW'(1);
          end
        end else if (col_q == '0) begin
          done_d   = 1'b1;
          cur_d    = '0;
          valid_d  = 1'b1;
          found_d  = 1'b0;
          packed_d = '0;
          state_d  = ST_IDLE;
        end else begin
          tgt_d   = col_m1;
          state_d = ST_POP;
        end
      end

      ST_POP: begin
        rows_d[v_idx]  = 1'b0;
        d1_d[p1_idx]   = 1'b0;
        d2_d[p2_idx]   = 1'b0;
        col_d          = col_m1;
        r_d            = CW'(rdata_q) + CW'(1);
        if (col_m1 == tgt_q) begin
          state_d = ST_SEARCH;
        end else begin
          mem_raddr = col_m2[AW-1:0];
        end
      end

      ST_PACK: begin
        if (pk_q != '0) begin
          packed_d[{pk_m1[2:0], 2'b00} +: RowW] = rdata_q;
        end
        if (pk_q == cnt) begin
          valid_d = 1'b1;
          found_d = 1'b1;
          state_d = ST_IDLE;
        end else begin
          mem_raddr = pk_q[AW-1:0];
          pk_d      = pk_q + PackCntW'(1);
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      board_size_q <= BoardSizeRst;
      col_q        <= '0;
      r_q          <= '0;
      cur_q        <= '0;
      tgt_q        <= '0;
      done_q       <= 1'b0;
      started_q    <= 1'b0;
      rows_q       <= '0;
      d1_q         <= '0;
      d2_q         <= '0;
      pk_q         <= '0;
      valid_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      col_q     <= col_d;
      r_q       <= r_d;
      cur_q     <= cur_d;
      tgt_q     <= tgt_d;
      done_q    <= done_d;
      started_q <= started_d;
      rows_q    <= rows_d;
      d1_q      <= d1_d;
      d2_q      <= d2_d;
      pk_q      <= pk_d;
      valid_q   <= valid_d;
      if (cfg_we_i) begin
        board_size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    found_q  <= found_d;
    packed_q <= packed_d;
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign valid_o       = valid_q;
  assign found_o       = found_q;
  assign rows_packed_o = packed_q;

  // row mask holds exactly one bit per stacked column
  `ASSERT_CLK(a_mask_height, $countones(rows_q) == col_q, "row mask out of step with stack")
  `ASSERT_NEVER(a_col_range, col_q > CW'(MAX_QUEENS), "stack height beyond board")
  `ASSERT_CLK(a_notfound_zero, (valid_o && !found_o) |-> (rows_packed_o == '0),
              "not-found item carries rows")
  `ASSERT_CLK(a_busy_ends_item, $fell(busy_o) |-> valid_o, "busy dropped without an item")

endmodule

// ===== sim/tb_top.sv =====
// Testbench for n_queens_solution_enumerator_top: drives restart/continue items,
// predicts every solution by its own backtracking search and checks each result.
// Depends on nqse_pkg and the RTL of the enumerator.
module tb_top
  import nqse_pkg::*;
();

  logic                  clk;
  logic                  rst_n;
  logic                  start_i;
  logic                  busy_o;
  logic                  restart_i;
  logic                  cfg_we_i;
  logic [BoardSizeW-1:0] cfg_wdata_i;
  logic                  valid_o;
  logic                  found_o;
  logic [PackW-1:0]      rows_packed_o;

  n_queens_solution_enumerator_top dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .restart_i    (restart_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .valid_o      (valid_o),
    .found_o      (found_o),
    .rows_packed_o(rows_packed_o)
  );

  class solution_tracker;
    typedef struct packed {
      logic             found;
      logic [PackW-1:0] rows;
    } solution_t;

    solution_t             awaited_solutions[$];
    logic [RowW-1:0]       queen_row[MaxQueensDef];
    logic [BoardSizeW-1:0] board_size;
    int                    last_depth;
    bit                    exhausted;
    bit                    started;
    int unsigned           errors;

    function new();
      board_size = BoardSizeRst;
      foreach (queen_row[i]) queen_row[i] = '0;
      last_depth = 0;
      exhausted  = 0;
      started    = 0;
      errors     = 0;
    endfunction

    function void set_board_size(logic [BoardSizeW-1:0] v);
      board_size = v;
    endfunction

    function int pending();
      return awaited_solutions.size();
    endfunction

    function bit row_is_safe(int col, int r);
      for (int i = 0; i < col; i++) begin
        if (int'(queen_row[i]) == r) return 0;
        if (int'(queen_row[i]) + col == r + i) return 0;
        if (int'(queen_row[i]) + i == r + col) return 0;
      end
      return 1;
    endfunction

    // Runs the search up to the next solution or to exhaustion.
    function void note_request(bit restart);
      int        n;
      int        col;
      int        r;
      int        depth;
      bit        solved;
      bit        gave_up;
      solution_t sol;
      n = int'(board_size);
      if (n > MaxQueensDef) n = MaxQueensDef;
      solved  = 0;
      gave_up = 0;
      col     = 0;
      r       = 0;
      if (restart || !started) begin
        foreach (queen_row[i]) queen_row[i] = '0;
        started    = 1;
        exhausted  = 0;
        last_depth = 0;
        if (n == 0) solved = 1;
      end else if (exhausted) begin
        gave_up = 1;
      end else begin
        depth = (last_depth > n) ? n : last_depth;
        if (depth == 0) begin
          gave_up = 1;
        end else begin
          col = depth - 1;
          r   = int'(queen_row[col]) + 1;
        end
      end
      while (!solved && !gave_up) begin
        if (r < n) begin
          if (row_is_safe(col, r)) begin
            queen_row[col] = RowW'(r);
            col++;
            if (col >= n) solved = 1;
            else r = 0;
          end else begin
            r++;
          end
        end else if (col == 0) begin
          gave_up = 1;
        end else begin
          col--;
          r = int'(queen_row[col]) + 1;
        end
      end
      sol = '0;
      if (solved) begin
        last_depth = n;
        exhausted  = 0;
        sol.found  = 1'b1;
        for (int k = 0; k < n && k < PackCols; k++) sol.rows[RowW*k +: RowW] = queen_row[k];
      end else begin
        exhausted  = 1;
        last_depth = 0;
      end
      awaited_solutions.push_back(sol);
    endfunction

    function void check_solution(logic found, logic [PackW-1:0] rows);
      solution_t want;
      if (awaited_solutions.size() == 0) begin
        $error("result with nothing awaited: found=%0b rows_packed=%h", found, rows);
        errors++;
        return;
      end
      want = awaited_solutions.pop_front();
      if (found !== want.found) begin
        $error("found: expected %0b, actual %0b", want.found, found);
        errors++;
      end
      if (rows !== want.rows) begin
        $error("rows_packed: expected %h, actual %h", want.rows, rows);
        errors++;
      end
    endfunction
  endclass

  solution_tracker tracker = new();
  int              burst_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && valid_o) tracker.check_solution(found_o, rows_packed_o);
  end

  // Leaves start high on acceptance unless a gap follows the burst.
  task automatic send_item(bit restart);
    int gap;
    start_i   <= 1'b1;
    restart_i <= restart;
    do @(posedge clk); while (busy_o);
    tracker.note_request(restart);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        start_i   <= 1'b0;
        restart_i <= 1'($urandom_range(0, 1));
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained(int settle);
    int guard;
    guard = 0;
    start_i <= 1'b0;
    while (tracker.pending() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_board_size(logic [BoardSizeW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    tracker.set_board_size(v);
    @(posedge clk);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(logic [BoardSizeW-1:0] size, int n_items, bit first_restart);
    write_board_size(size);
    for (int i = 0; i < n_items; i++) begin
      send_item((i == 0 && first_restart) || $urandom_range(0, 15) == 0);
    end
    wait_drained(4);
  endtask

  initial begin
    int                    random_items;
    int                    n_items;
    int                    pick;
    logic [BoardSizeW-1:0] size;
    rst_n       <= 1'b0;
    start_i     <= 1'b0;
    restart_i   <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    burst_left  = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // continue before any restart, at the reset board size
    send_item(1'b0);
    wait_drained(4);
    write_board_size(4'd1);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b0);
    wait_drained(4);
    // empty board, then a size above the maximum
    write_board_size(4'd0);
    send_item(1'b1);
    send_item(1'b0);
    wait_drained(4);
    write_board_size(4'd15);
    send_item(1'b1);
    send_item(1'b0);
    wait_drained(4);
    write_board_size(4'd4);
    for (int i = 0; i < 4; i++) send_item(i == 0);
    wait_drained(4);
    write_board_size(4'd2);
    send_item(1'b1);
    wait_drained(4);
    write_board_size(4'd3);
    send_item(1'b1);
    send_item(1'b0);
    wait_drained(4);
    // size changed mid-search
    write_board_size(4'd8);
    send_item(1'b1);
    send_item(1'b0);
    wait_drained(4);
    write_board_size(4'd5);
    send_item(1'b0);
    send_item(1'b0);
    wait_drained(4);
    write_board_size(4'd8);
    send_item(1'b0);
    wait_drained(4);

    random_items = 0;
    while (random_items < 1350) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) size = BoardSizeW'($urandom_range(0, 15));
      else if (pick < 3) size = BoardSizeW'($urandom_range(1, 5));
      else size = BoardSizeW'($urandom_range(6, 8));
      n_items = $urandom_range(5, 40);
      run_phase(size, n_items, $urandom_range(0, 3) != 0);
      random_items += n_items;
    end

    wait_drained(20);
    if (tracker.pending() != 0) begin
      $error("%0d results never arrived", tracker.pending());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #200000000;
    $display("tb: failure");
    $finish;
  end

endmodule
